/* rtl/core/acs_pkg.sv */
// shared types, opcodes and decode helpers for the accumulator step core
package acs_pkg;

	localparam int PROGRAM_DEPTH_DEF  = 256;
	localparam int USER_REG_COUNT_DEF = 16;
	localparam int STACK_DEPTH_DEF    = 16;

	// kind of input item, carried in the slave tuser bit
	localparam logic OPER_LOAD = 1'b0;
	localparam logic OPER_STEP = 1'b1;

	typedef enum logic [7:0] {
		OP_HLT = 8'h00, OP_NOP = 8'h01, OP_OTI = 8'h02, OP_LDA = 8'h03,
		OP_LDI = 8'h04, OP_ADD = 8'h05, OP_SUB = 8'h06, OP_STA = 8'h07,
		OP_AND = 8'h08, OP_ORL = 8'h09, OP_XOR = 8'h0A, OP_NOT = 8'h0B,
		OP_GTA = 8'h0C, OP_IFC = 8'h0D, OP_IFZ = 8'h0E, OP_IFE = 8'h0F,
		OP_ITI = 8'h10, OP_SHR = 8'h11, OP_SHL = 8'h12, OP_CPA = 8'h13,
		OP_ADA = 8'h14, OP_SBA = 8'h15, OP_ANA = 8'h16, OP_ORA = 8'h17,
		OP_XRA = 8'h18, OP_SWA = 8'h19, OP_PUH = 8'h1A, OP_POP = 8'h1B,
		OP_CSR = 8'h1C, OP_RET = 8'h1D
	} opcode_t;

	typedef enum logic [2:0] {
		FAULT_NONE   = 3'd0,
		FAULT_OPCODE = 3'd1,
		FAULT_REG    = 3'd2,
		FAULT_FULL   = 3'd3,
		FAULT_EMPTY  = 3'd4
	} fault_t;

	typedef enum logic [1:0] {
		SEQ_IDLE = 2'd0,
		SEQ_OP   = 2'd1,
		SEQ_ARG  = 2'd2
	} seq_t;

	typedef struct packed {
		logic [7:0] acc;
		logic [7:0] pc;
		logic       carry;
		logic       zero;
		logic       equal;
		logic       halt;
		fault_t     fault;
		logic       out_valid;
		logic [7:0] out_value;
		logic       reg_we;
		logic       push;
		logic       pop;
		logic [7:0] push_val;
	} exec_res_t;

	// operand byte names a user register
	function automatic logic is_reg_op(input logic [7:0] op);
		return (op == OP_LDA) || (op == OP_STA) || ((op >= OP_ADA) && (op <= OP_XRA));
	endfunction

	// instruction carries an operand byte after the opcode
	function automatic logic need_arg(input logic [7:0] op);
		return is_reg_op(op) || ((op >= OP_LDI) && (op <= OP_XOR)) ||
			((op >= OP_GTA) && (op <= OP_IFE)) || ((op >= OP_SHR) && (op <= OP_CPA)) ||
			(op == OP_CSR);
	endfunction

endpackage

/* rtl/core/acs_pmem.sv */
// single-port program memory with per-entry valid bits and a registered read
module acs_pmem #(
	parameter int DEPTH = acs_pkg::PROGRAM_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  logic       rd_en,
	input  logic [7:0] addr,
	input  logic [7:0] wdata,
	output logic [7:0] rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [7:0]       rdat_q;
	logic             zero_q;
	logic             oor;
	logic [AW-1:0]    idx;

	assign oor = {1'b0, addr} >= 9'(DEPTH);
	assign idx = addr[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en && !oor) begin
			mem[idx] <= wdata;
		end
		if (rd_en) begin
			rdat_q <= mem[idx];
		end
	end

	// entries never written and addresses past the end read as halt
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			zero_q <= 1'b1;
		end else begin
			if (wr_en && !oor) begin
				vld_q[idx] <= 1'b1;
			end
			if (rd_en) begin
				zero_q <= oor || !vld_q[idx];
			end
		end
	end

	assign rdata = zero_q ? 8'h00 : rdat_q;

endmodule

/* rtl/core/acs_exec.sv */
// instruction execute unit: alu, flags, branch and stack decisions
module acs_exec #(
	parameter int USER_REG_COUNT = acs_pkg::USER_REG_COUNT_DEF,
	parameter int STACK_DEPTH    = acs_pkg::STACK_DEPTH_DEF
) (
	input  logic [7:0]                       op,
	input  logic [7:0]                       arg,
	input  logic [7:0]                       acc,
	input  logic [7:0]                       pc,
	input  logic                             carry,
	input  logic                             zero,
	input  logic                             equal,
	input  logic [7:0]                       in_port,
	input  logic [7:0]                       reg_val,
	input  logic [7:0]                       stk_top,
	input  logic [$clog2(STACK_DEPTH+1)-1:0] fill,
	output acs_pkg::exec_res_t               res
);

	localparam int FW = $clog2(STACK_DEPTH + 1);

	logic       reg_ok;
	logic       full;
	logic       empty;
	logic [7:0] pc_seq;
	logic [7:0] nacc;
	logic       setz;
	logic [8:0] sum;
	logic [7:0] opnd;

	assign reg_ok = {1'b0, arg} < 9'(USER_REG_COUNT);
	assign full   = fill >= FW'(STACK_DEPTH);
	assign empty  = fill == '0;
	assign pc_seq = acs_pkg::need_arg(op) ? 8'(pc + 8'd2) : 8'(pc + 8'd1);
	assign opnd   = acs_pkg::is_reg_op(op) ? reg_val : arg;
	assign sum    = {1'b0, acc} + {1'b0, opnd};

	always_comb begin
		nacc          = acc;
		setz          = 1'b0;
		res.acc       = acc;
		res.pc        = pc_seq;
		res.carry     = carry;
		res.zero      = zero;
		res.equal     = equal;
		res.halt      = 1'b0;
		res.fault     = acs_pkg::FAULT_NONE;
		res.out_valid = 1'b0;
		res.out_value = 8'h00;
		res.reg_we    = 1'b0;
		res.push      = 1'b0;
		res.pop       = 1'b0;
		res.push_val  = acc;
		if (acs_pkg::is_reg_op(op) && !reg_ok) begin
			res.fault = acs_pkg::FAULT_REG;
		end else begin
			unique case (op)
				acs_pkg::OP_HLT: res.halt = 1'b1;
				acs_pkg::OP_NOP: ;
				acs_pkg::OP_OTI: begin
					res.out_valid = 1'b1;
					res.out_value = acc;
				end
				acs_pkg::OP_LDA: begin nacc = reg_val; setz = 1'b1; end
				acs_pkg::OP_LDI: nacc = arg;
				acs_pkg::OP_ADD, acs_pkg::OP_ADA: begin
					nacc      = sum[7:0];
					res.carry = sum[8];
					setz      = 1'b1;
				end
				acs_pkg::OP_SUB, acs_pkg::OP_SBA: begin
					nacc      = 8'(acc - opnd);
					res.carry = acc < opnd;
					setz      = 1'b1;
				end
				acs_pkg::OP_STA: res.reg_we = 1'b1;
				acs_pkg::OP_AND, acs_pkg::OP_ANA: begin nacc = acc & opnd; setz = 1'b1; end
				acs_pkg::OP_ORL, acs_pkg::OP_ORA: begin nacc = acc | opnd; setz = 1'b1; end
				acs_pkg::OP_XOR, acs_pkg::OP_XRA: begin nacc = acc ^ opnd; setz = 1'b1; end
				acs_pkg::OP_NOT: begin nacc = ~acc; setz = 1'b1; end
				acs_pkg::OP_GTA: res.pc = arg;
				acs_pkg::OP_IFC: if (carry) res.pc = arg;
				acs_pkg::OP_IFZ: if (zero) res.pc = arg;
				acs_pkg::OP_IFE: if (equal) res.pc = arg;
				acs_pkg::OP_ITI: nacc = in_port;
				acs_pkg::OP_SHR: begin
					nacc = (arg >= 8'd8) ? 8'h00 : (acc >> arg[2:0]);
					setz = 1'b1;
				end
				acs_pkg::OP_SHL: begin
					nacc = (arg >= 8'd8) ? 8'h00 : 8'(acc << arg[2:0]);
					setz = 1'b1;
				end
				acs_pkg::OP_CPA: res.equal = acc == arg;
				acs_pkg::OP_SWA: nacc = {acc[3:0], acc[7:4]};
				acs_pkg::OP_PUH: begin
					if (full) res.fault = acs_pkg::FAULT_FULL;
					else res.push = 1'b1;
				end
				acs_pkg::OP_POP: begin
					if (empty) begin
						res.fault = acs_pkg::FAULT_EMPTY;
					end else begin
						res.pop = 1'b1;
						nacc    = stk_top;
						setz    = 1'b1;
					end
				end
				acs_pkg::OP_CSR: begin
					res.push_val = pc_seq;
					if (full) begin
						res.fault = acs_pkg::FAULT_FULL;
					end else begin
						res.push = 1'b1;
						res.pc   = arg;
					end
				end
				acs_pkg::OP_RET: begin
					if (empty) begin
						res.fault = acs_pkg::FAULT_EMPTY;
					end else begin
						res.pop = 1'b1;
						res.pc  = stk_top;
					end
				end
				default: begin
					res.halt  = 1'b1;
					res.fault = acs_pkg::FAULT_OPCODE;
				end
			endcase
		end
		res.acc = nacc;
		if (setz) res.zero = nacc == 8'h00;
	end

endmodule

/* rtl/core/accumulator_cpu_step_core.sv */
// top level of the accumulator step core: sequencer, architectural state, result register
//
// channel  | dir | handshake                    | payload
// ---------+-----+------------------------------+------------------------------------------------
// s_*      | in  | s_tvalid / s_tready          | tuser: operation; tdata: address, data, in port
// m_*      | out | m_tvalid / m_tready          | tuser: output_valid; tdata: value, acc, pc, flags
//
// a load transfer or a one-byte instruction holds the core in the opcode phase after its transfer,
// a two-byte instruction in the opcode and then the operand phase; the result register loads at the
// end of the last of them, once it is free. the single port of the program memory sets this: opcode
// and operand are two separate reads. the next item is taken in the cycle its predecessor executes,
// fetching at the new pc. reset clears acc, pc, flags, halt latch, registers, stack and all program
// valid bits at once. a held result register stalls completion only; a new item still starts once the core is idle.
module accumulator_cpu_step_core #(
	parameter int PROGRAM_DEPTH  = acs_pkg::PROGRAM_DEPTH_DEF,
	parameter int USER_REG_COUNT = acs_pkg::USER_REG_COUNT_DEF,
	parameter int STACK_DEPTH    = acs_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // program_address[7:0], program_data[15:8], input_port_value[23:16]
	input  logic [0:0]  s_tuser,   // operation[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // output_value, acc_value, pc_value, carry, zero, equal, halted, fault
	output logic [0:0]  m_tuser    // output_valid[0]
);

	localparam int RW = (USER_REG_COUNT > 1) ? $clog2(USER_REG_COUNT) : 1;
	localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int FW = $clog2(STACK_DEPTH + 1);

	// architectural state
	logic [7:0]    acc_q;
	logic [7:0]    pc_q;
	logic          carry_q;
	logic          zero_q;
	logic          equal_q;
	logic          halt_q;
	logic [7:0]    regs_q [USER_REG_COUNT];
	logic [7:0]    stk_q [STACK_DEPTH];
	logic [FW-1:0] fill_q;

	// sequencer and item registers
	acs_pkg::seq_t state_q, state_d;
	logic          kind_s1;
	logic [7:0]    inport_s1;
	logic [7:0]    opcode_s1;

	// result register
	logic          m_tvalid_q;
	logic [31:0]   m_tdata_q;
	logic          m_tuser_q;

	logic               in_fire;
	logic               out_free;
	logic               finish;
	logic               go_arg;
	logic               upd;
	logic [7:0]         rd_byte;
	logic [7:0]         cur_op;
	logic [7:0]         reg_val;
	logic [7:0]         stk_top;
	logic [FW-1:0]      top_idx;
	logic [7:0]         pc_issue;
	logic [7:0]         mem_addr;
	logic               mem_rd;
	logic               mem_wr;
	acs_pkg::exec_res_t res;
	logic [31:0]        out_data;
	logic               out_flag;

	assign out_free = !m_tvalid_q || m_tready;
	assign in_fire  = s_tvalid && s_tready;

	// in the operand phase the opcode sits in opcode_s1 and the memory returns the operand
	assign cur_op  = (state_q == acs_pkg::SEQ_ARG) ? opcode_s1 : rd_byte;
	assign reg_val = regs_q[rd_byte[RW-1:0]];
	assign top_idx = fill_q - FW'(1);
	assign stk_top = stk_q[top_idx[SW-1:0]];

	acs_exec #(
		.USER_REG_COUNT(USER_REG_COUNT),
		.STACK_DEPTH   (STACK_DEPTH)
	) u_exec (
		.op     (cur_op),
		.arg    (rd_byte),
		.acc    (acc_q),
		.pc     (pc_q),
		.carry  (carry_q),
		.zero   (zero_q),
		.equal  (equal_q),
		.in_port(inport_s1),
		.reg_val(reg_val),
		.stk_top(stk_top),
		.fill   (fill_q),
		.res    (res)
	);

	// sequencer: next state, completion and memory port control
	always_comb begin
		state_d = state_q;
		finish  = 1'b0;
		go_arg  = 1'b0;
		unique case (state_q)
			acs_pkg::SEQ_IDLE: ;
			acs_pkg::SEQ_OP: begin
				if (kind_s1 == acs_pkg::OPER_LOAD || halt_q) begin
					finish = out_free;
				end else if (acs_pkg::need_arg(rd_byte)) begin
					go_arg = 1'b1;
				end else begin
					finish = out_free;
				end
			end
			acs_pkg::SEQ_ARG: finish = out_free;
			default: ;
		endcase
		s_tready = (state_q == acs_pkg::SEQ_IDLE) || finish;
		if (s_tready) begin
			state_d = in_fire ? acs_pkg::SEQ_OP : acs_pkg::SEQ_IDLE;
		end else if (go_arg) begin
			state_d = acs_pkg::SEQ_ARG;
		end
	end

	assign upd      = finish && (kind_s1 == acs_pkg::OPER_STEP) && !halt_q;
	// an item taken as one executes fetches its opcode at the updated pc
	assign pc_issue = upd ? res.pc : pc_q;
	assign mem_wr   = in_fire && (s_tuser[0] == acs_pkg::OPER_LOAD);
	assign mem_rd   = go_arg || (in_fire && (s_tuser[0] == acs_pkg::OPER_STEP));
	assign mem_addr = go_arg ? 8'(pc_q + 8'd1) :
		((s_tuser[0] == acs_pkg::OPER_STEP) ? pc_issue : s_tdata[7:0]);

	acs_pmem #(
		.DEPTH(PROGRAM_DEPTH)
	) u_pmem (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_en (mem_wr),
		.rd_en (mem_rd),
		.addr  (mem_addr),
		.wdata (s_tdata[15:8]),
		.rdata (rd_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= acs_pkg::SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// item payload held while the instruction is fetched
	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1   <= s_tuser[0];
			inport_s1 <= s_tdata[23:16];
		end
		if (go_arg) begin
			opcode_s1 <= rd_byte;
		end
	end

	// architectural state update at the end of a step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= 8'h00;
			pc_q    <= 8'h00;
			carry_q <= 1'b0;
			zero_q  <= 1'b0;
			equal_q <= 1'b0;
			halt_q  <= 1'b0;
			fill_q  <= '0;
			for (int i = 0; i < USER_REG_COUNT; i++) regs_q[i] <= 8'h00;
			for (int i = 0; i < STACK_DEPTH; i++) stk_q[i] <= 8'h00;
		end else if (upd) begin
			acc_q   <= res.acc;
			pc_q    <= res.pc;
			carry_q <= res.carry;
			zero_q  <= res.zero;
			equal_q <= res.equal;
			halt_q  <= res.halt;
			if (res.reg_we) begin
				regs_q[rd_byte[RW-1:0]] <= acc_q;
			end
			if (res.push) begin
				stk_q[fill_q[SW-1:0]] <= res.push_val;
				fill_q                <= fill_q + FW'(1);
			end else if (res.pop) begin
				fill_q <= top_idx;
			end
		end
	end

	// result word: loads and halted steps report the state unchanged
	always_comb begin
		if (upd) begin
			out_flag = res.out_valid;
			out_data = {1'b0, res.fault, res.halt, res.equal, res.zero, res.carry,
				res.pc, res.acc, res.out_value};
		end else begin
			out_flag = 1'b0;
			out_data = {1'b0, acs_pkg::FAULT_NONE, halt_q, equal_q, zero_q, carry_q,
				pc_q, acc_q, 8'h00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			m_tdata_q <= out_data;
			m_tuser_q <= out_flag;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

	// the single memory port never sees a read and a write together
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n) !(mem_rd && mem_wr))
		else $error("program memory read and write in one cycle");

	// once halted only reset restarts execution
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n) halt_q |=> halt_q)
		else $error("halt latch cleared");

	// the stack never holds more than its depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(STACK_DEPTH))
		else $error("stack fill beyond depth");

	// the operand phase only follows an opcode phase or an operand phase that is held
	a_arg_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == acs_pkg::SEQ_ARG) |->
		($past(state_q) == acs_pkg::SEQ_OP || $past(state_q) == acs_pkg::SEQ_ARG))
		else $error("operand phase entered without opcode fetch");

endmodule
